[rtl/size_weighted_lru_cache_unit_defines.svh]
// Assertion macros for the size weighted LRU cache unit.
`ifndef SIZE_WEIGHTED_LRU_CACHE_UNIT_DEFINES_SVH
`define SIZE_WEIGHTED_LRU_CACHE_UNIT_DEFINES_SVH

`define SWL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SWL_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/swlru_pkg.sv]
// ----------------------------------------------------------------------------
// swlru_pkg
// Status codes and defaults shared by the cache unit.
// ----------------------------------------------------------------------------
package swlru_pkg;
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_KEY_BITS  = 16;
    localparam int DEF_SIZE_BITS = 24;
    localparam int STATUS_BITS   = 3;

    localparam logic [STATUS_BITS-1:0] ST_BYPASS    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_HIT       = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EVICT     = 3'd4;

    typedef logic [STATUS_BITS-1:0] status_t;
endpackage

[rtl/swlru_store.sv]
// ----------------------------------------------------------------------------
// swlru_store
// Entry memory: key and size per slot, one write port, one registered read.
// ----------------------------------------------------------------------------
module swlru_store #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 16,
    parameter int SIZE_BITS = 24,
    parameter int IDX_BITS  = $clog2(ENTRIES)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_BITS-1:0]  waddr,
    input  logic [KEY_BITS-1:0]  wkey,
    input  logic [SIZE_BITS-1:0] wbytes,
    input  logic [IDX_BITS-1:0]  raddr,
    output logic [KEY_BITS-1:0]  rkey,
    output logic [SIZE_BITS-1:0] rbytes
);
    logic [KEY_BITS+SIZE_BITS-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wkey, wbytes};
        end
        {rkey, rbytes} <= mem[raddr];
    end
endmodule

[rtl/size_weighted_lru_cache_unit.sv]
// ----------------------------------------------------------------------------
// size_weighted_lru_cache_unit
// Size aware LRU cache controller with entry memory and a slot sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//  cfg     | input     | cfg_valid / cfg_ready
// A request passes through the key scan over the entry memory read port, then
// decide, result and idle. Each eviction adds an eviction read and write-back;
// a bypass goes from idle straight to result, with no scan.
// Reset clears valid bits, ranks, byte count; the memory is not cleared.
// A stalled result holds the sequencer at decide, eviction write-back and
// result; a new request may be taken while the final result still waits.
module size_weighted_lru_cache_unit #(
    parameter int ENTRIES   = swlru_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = swlru_pkg::DEF_KEY_BITS,
    parameter int SIZE_BITS = swlru_pkg::DEF_SIZE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KEY_BITS-1:0]  object_key,
    input  logic [SIZE_BITS-1:0] object_bytes,
    input  logic                 found_on_disk,
    output logic                 out_valid,
    input  logic                 out_stall,
    output swlru_pkg::status_t   status,
    output logic [KEY_BITS-1:0]  evicted_key,
    output logic [SIZE_BITS-1:0] bytes_in_use,
    output logic                 last_result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SIZE_BITS-1:0] cfg_data
);
    import swlru_pkg::*;
    `include "size_weighted_lru_cache_unit_defines.svh"

    localparam int IB = $clog2(ENTRIES);
    localparam int CB = $clog2(ENTRIES + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2,
                           S_EVRD = 4'd3, S_EVWT = 4'd4, S_OUT = 4'd5;

    logic [3:0]           st_reg, st_next;
    logic [SIZE_BITS-1:0] cap_reg;
    logic [ENTRIES-1:0]   vld_reg;
    logic [IB-1:0]        rank_reg [ENTRIES];
    logic [SIZE_BITS-1:0] used_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [SIZE_BITS-1:0] sz_reg;
    logic                 pres_reg;
    logic [IB-1:0]        ptr_reg;
    logic                 rd_pend_reg;
    logic [IB-1:0]        rd_idx_reg;
    logic                 hit_reg;
    logic [IB-1:0]        hit_idx_reg;
    logic [CB-1:0]        cnt_reg;
    logic [IB-1:0]        lru_reg;
    logic                 ov_reg;
    status_t              ost_reg;
    logic [KEY_BITS-1:0]  okey_reg;
    logic                 olast_reg;

    logic                 we;
    logic [IB-1:0]        waddr, raddr, slot;
    logic [KEY_BITS-1:0]  rkey;
    logic [SIZE_BITS-1:0] rbytes;
    logic                 has_free;

    swlru_store #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .SIZE_BITS(SIZE_BITS))
    u_store (.clk(clk), .we(we), .waddr(waddr), .wkey(key_reg), .wbytes(sz_reg),
             .raddr(raddr), .rkey(rkey), .rbytes(rbytes));

    always_comb
    begin
        slot = '0;
        has_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!vld_reg[i])
            begin
                slot = IB'(i);
                has_free = 1'b1;
            end
        end
    end

    logic [SIZE_BITS:0] sum_w;
    logic               fits;
    assign sum_w = {1'b0, used_reg} + {1'b0, sz_reg};
    assign fits  = (sum_w <= {1'b0, cap_reg}) && (cnt_reg != CB'(ENTRIES));

    assign in_stall  = (st_reg != S_IDLE);
    assign cfg_ready = (st_reg == S_IDLE);
    assign raddr = ((st_reg == S_EVRD) || (st_reg == S_EVWT)) ? lru_reg : ptr_reg;
    assign we    = (st_reg == S_DEC) && !hit_reg && pres_reg && fits && has_free;
    assign waddr = slot;
    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign evicted_key  = okey_reg;
    assign bytes_in_use = used_reg;
    assign last_result  = olast_reg;

    logic out_free;
    assign out_free = !ov_reg || !out_stall;

    logic ov_set;
    assign ov_set = ((st_reg == S_EVWT) || (st_reg == S_OUT)) && out_free;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (in_valid) st_next = (object_bytes > cap_reg) ? S_OUT : S_SCAN;
            S_SCAN: if (rd_pend_reg && rd_idx_reg == IB'(ENTRIES - 1)) st_next = S_DEC;
            S_DEC:
                if (out_free)
                begin
                    if (hit_reg || !pres_reg || fits || cnt_reg == '0) st_next = S_OUT;
                    else st_next = S_EVRD;
                end
            S_EVRD: st_next = S_EVWT;
            S_EVWT: if (out_free) st_next = S_DEC;
            S_OUT: if (out_free) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            cap_reg     <= SIZE_BITS'(1048576);
            vld_reg     <= '0;
            used_reg    <= '0;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_set || (ov_reg && out_stall);
            if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
            case (st_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        key_reg  <= object_key;
                        sz_reg   <= object_bytes;
                        pres_reg <= found_on_disk;
                        ptr_reg  <= '0;
                        rd_pend_reg <= 1'b0;
                        hit_reg  <= 1'b0;
                        cnt_reg  <= '0;
                        lru_reg  <= '0;
                    end
                S_SCAN:
                begin
                    rd_pend_reg <= 1'b1;
                    rd_idx_reg  <= ptr_reg;
                    if (ptr_reg != IB'(ENTRIES - 1)) ptr_reg <= ptr_reg + 1'b1;
                    if (rd_pend_reg && vld_reg[rd_idx_reg])
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == '0 || rank_reg[rd_idx_reg] > rank_reg[lru_reg])
                            lru_reg <= rd_idx_reg;
                        if (!hit_reg && rkey == key_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                        end
                    end
                end
                S_DEC:
                    if (out_free)
                    begin
                        if (hit_reg)
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (vld_reg[i] && rank_reg[i] < rank_reg[hit_idx_reg])
                                    rank_reg[i] <= rank_reg[i] + 1'b1;
                            rank_reg[hit_idx_reg] <= '0;
                            ost_reg <= ST_HIT;
                        end
                        else if (!pres_reg)
                            ost_reg <= ST_NOT_FOUND;
                        else if (fits || cnt_reg == '0)
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                                if (vld_reg[i]) rank_reg[i] <= rank_reg[i] + 1'b1;
                            if (has_free)
                            begin
                                vld_reg[slot]  <= 1'b1;
                                rank_reg[slot] <= '0;
                                used_reg <= sum_w[SIZE_BITS-1:0];
                            end
                            ost_reg <= ST_INSERTED;
                        end
                    end
                S_EVWT:
                    if (out_free)
                    begin
                        vld_reg[lru_reg]  <= 1'b0;
                        rank_reg[lru_reg] <= '0;
                        used_reg <= (used_reg >= rbytes) ? used_reg - rbytes : '0;
                        ost_reg   <= ST_EVICT;
                        okey_reg  <= rkey;
                        olast_reg <= 1'b0;
                        cnt_reg   <= cnt_reg - 1'b1;
                        // next LRU has rank = old rank - 1
                        for (int i = 0; i < ENTRIES; i++)
                            if (vld_reg[i] && IB'(i) != lru_reg &&
                                rank_reg[i] == rank_reg[lru_reg] - 1'b1)
                                lru_reg <= IB'(i);
                    end
                S_OUT:
                    if (out_free)
                    begin
                        if (sz_reg > cap_reg) ost_reg <= ST_BYPASS;
                        okey_reg  <= '0;
                        olast_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

    `SWL_ASSERT(a_no_accept_busy, clk, rst_n, (st_reg != S_IDLE) |-> in_stall, "accept while busy")
    `SWL_ASSERT(a_we_scope, clk, rst_n, we |-> (st_reg == S_DEC), "write outside decide")
    `SWL_ASSERT(a_evict_not_last, clk, rst_n, (out_valid && status == ST_EVICT) |-> !last_result, "evict marked last")
endmodule

[dv/size_weighted_lru_cache_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_weighted_lru_cache_unit_tb
// Drives cache requests through a directed table and random phases, models
// the size weighted LRU policy and checks every result transfer in order.
// ----------------------------------------------------------------------------
module size_weighted_lru_cache_unit_tb;
    import swlru_pkg::*;

    localparam int NENT = DEF_ENTRIES;
    localparam int KB   = DEF_KEY_BITS;
    localparam int SB   = DEF_SIZE_BITS;
    localparam logic [SB-1:0] CAP_RESET = 24'd1048576;
    localparam logic [SB-1:0] CAP_MAX   = {SB{1'b1}};

    typedef struct packed {
        status_t       st;
        logic [KB-1:0] ekey;
        logic [SB-1:0] used;
        logic          last;
    } cache_result_t;

    typedef struct {
        logic [KB-1:0] key;
        logic [SB-1:0] nbytes;
        logic          on_disk;
        bit            fixed;
        status_t       fixed_st;
    } request_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [KB-1:0] object_key = '0;
    logic [SB-1:0] object_bytes = '0;
    logic found_on_disk = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    status_t status;
    logic [KB-1:0] evicted_key;
    logic [SB-1:0] bytes_in_use;
    logic last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SB-1:0] cfg_data = '0;

    // mirror of cache contents
    logic [KB-1:0] m_key [NENT];
    logic [SB-1:0] m_bytes [NENT];
    bit            m_valid [NENT];
    int unsigned   m_rank [NENT];
    logic [SB-1:0] m_used;
    logic [SB-1:0] m_cap;

    cache_result_t pending_results[$];
    int err_count = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;

    always #5 clk = ~clk;

    size_weighted_lru_cache_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .object_key(object_key), .object_bytes(object_bytes),
        .found_on_disk(found_on_disk),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .evicted_key(evicted_key),
        .bytes_in_use(bytes_in_use), .last_result(last_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    task automatic report_mismatch(input string what);
        $display("%0t MISMATCH: %s", $time, what);
        err_count++;
    endtask

    task automatic push_result(input status_t st, input logic [KB-1:0] ek, input logic lst);
        cache_result_t r;
        r.st = st;
        r.ekey = ek;
        r.used = m_used;
        r.last = lst;
        pending_results.push_back(r);
    endtask

    task automatic predict_lookup(input logic [KB-1:0] key, input logic [SB-1:0] nb,
                                  input logic on_disk);
        int hit;
        int lru;
        int cnt;
        int slot;
        int unsigned r;
        hit = -1;
        slot = -1;
        if (nb > m_cap) begin
            push_result(ST_BYPASS, '0, 1'b1);
            return;
        end
        for (int i = 0; i < NENT; i++)
            if (hit < 0 && m_valid[i] && m_key[i] == key)
                hit = i;
        if (hit >= 0) begin
            r = m_rank[hit];
            for (int i = 0; i < NENT; i++)
                if (m_valid[i] && m_rank[i] < r)
                    m_rank[i]++;
            m_rank[hit] = 0;
            push_result(ST_HIT, '0, 1'b1);
            return;
        end
        if (!on_disk) begin
            push_result(ST_NOT_FOUND, '0, 1'b1);
            return;
        end
        forever begin
            cnt = 0;
            lru = -1;
            for (int i = 0; i < NENT; i++)
                if (m_valid[i]) begin
                    cnt++;
                    if (lru < 0 || m_rank[i] > m_rank[lru])
                        lru = i;
                end
            if (lru < 0)
                break;
            if ({1'b0, m_used} + {1'b0, nb} <= {1'b0, m_cap} && cnt < NENT)
                break;
            m_valid[lru] = 1'b0;
            m_rank[lru] = 0;
            m_used = (m_used >= m_bytes[lru]) ? m_used - m_bytes[lru] : '0;
            push_result(ST_EVICT, m_key[lru], 1'b0);
        end
        for (int i = 0; i < NENT; i++)
            if (slot < 0 && !m_valid[i])
                slot = i;
        for (int i = 0; i < NENT; i++)
            if (m_valid[i])
                m_rank[i]++;
        if (slot >= 0) begin
            m_valid[slot] = 1'b1;
            m_key[slot] = key;
            m_bytes[slot] = nb;
            m_rank[slot] = 0;
            m_used = m_used + nb;
        end
        push_result(ST_INSERTED, '0, 1'b1);
    endtask

    // valid stays high after a transfer until the next request or an idle cycle
    task automatic send_request(input logic [KB-1:0] key, input logic [SB-1:0] nb,
                                input logic on_disk);
        while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        object_key <= key;
        object_bytes <= nb;
        found_on_disk <= on_disk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_lookup(key, nb, on_disk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * NENT + 40) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [SB-1:0] cap);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        m_cap = cap;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d", status));
                end else begin
                    cache_result_t e;
                    e = pending_results.pop_front();
                    if (status !== e.st)
                        report_mismatch($sformatf("status %0d exp %0d", status, e.st));
                    if (evicted_key !== e.ekey)
                        report_mismatch($sformatf("evicted_key %h exp %h",
                                                  evicted_key, e.ekey));
                    if (bytes_in_use !== e.used)
                        report_mismatch($sformatf("bytes_in_use %0d exp %0d",
                                                  bytes_in_use, e.used));
                    if (last_result !== e.last)
                        report_mismatch($sformatf("last_result %b exp %b",
                                                  last_result, e.last));
                end
            end
            out_stall <= (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct);
        end
    end

    function automatic request_row_t row(input logic [KB-1:0] k, input logic [SB-1:0] b,
                                         input logic d, input bit fx, input status_t s);
        request_row_t t;
        t.key = k;
        t.nbytes = b;
        t.on_disk = d;
        t.fixed = fx;
        t.fixed_st = s;
        return t;
    endfunction

    task automatic run_random(input int n, input int key_span);
        logic [SB-1:0] nb;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: nb = SB'($urandom_range(CAP_MAX));
                1: nb = '0;
                default: nb = SB'($urandom_range(m_cap / 4 + 1));
            endcase
            send_request(KB'($urandom_range(key_span)), nb, $urandom_range(9) != 0);
        end
    endtask

    initial begin
        request_row_t dir_rows[$];
        cache_result_t first_exp;
        for (int i = 0; i < NENT; i++) begin
            m_valid[i] = 1'b0;
            m_rank[i] = 0;
            m_key[i] = '0;
            m_bytes[i] = '0;
        end
        m_used = '0;
        m_cap = CAP_RESET;

        dir_rows.push_back(row(16'h0000, 24'd100, 1'b0, 1'b1, ST_NOT_FOUND));
        dir_rows.push_back(row(16'hFFFF, CAP_MAX, 1'b1, 1'b1, ST_BYPASS));
        dir_rows.push_back(row(16'h0001, 24'd0, 1'b1, 1'b1, ST_INSERTED));
        dir_rows.push_back(row(16'h0001, CAP_RESET, 1'b1, 1'b1, ST_HIT));
        dir_rows.push_back(row(16'h0001, CAP_RESET + 24'd1, 1'b1, 1'b1, ST_BYPASS));
        dir_rows.push_back(row(16'hFFFF, CAP_RESET, 1'b1, 1'b0, ST_BYPASS));
        for (int i = 2; i < 20; i++)
            dir_rows.push_back(row(KB'(i * 16'h0F0F), 24'd10, 1'b1, 1'b0, ST_BYPASS));
        dir_rows.push_back(row(16'h5555, 24'd1000, 1'b0, 1'b1, ST_NOT_FOUND));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].key, dir_rows[i].nbytes, dir_rows[i].on_disk);
            if (dir_rows[i].fixed) begin
                first_exp = pending_results[pending_results.size() - 1];
                if (first_exp.st != dir_rows[i].fixed_st)
                    report_mismatch($sformatf("row %0d predicted status %0d exp %0d",
                                              i, first_exp.st, dir_rows[i].fixed_st));
            end
        end

        // budget lowered below bytes in use, then the extremes
        write_capacity(24'd5);
        send_request(16'h7777, 24'd3, 1'b1);
        write_capacity(24'd0);
        send_request(16'h8888, 24'd0, 1'b1);
        send_request(16'h8889, 24'd1, 1'b1);
        write_capacity(CAP_MAX);
        send_request(16'h9999, CAP_MAX, 1'b1);
        send_request(16'h9998, 24'd1, 1'b1);

        in_idle_pct = 37;
        out_idle_pct = 68;
        write_capacity(24'd4000);
        run_random(110, 40);
        in_idle_pct = 68;
        out_idle_pct = 37;
        write_capacity(24'd1);
        run_random(40, 7);
        write_capacity(24'd300000);
        run_random(70, 63);
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_capacity(CAP_RESET);
        run_random(80, 25);

        wait_drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/swlru_pkg.sv
rtl/swlru_store.sv
rtl/size_weighted_lru_cache_unit.sv
dv/size_weighted_lru_cache_unit_tb.sv
